@@ sv/wtj_pkg.sv @@
package wtj_pkg;

  localparam int HOLD_DEPTH = 8;
  localparam int MAX_PREFIX = 8;
  localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int PLEN_W     = 4;
  localparam int PREFIX_W   = 64;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEANUP_ENABLE = 2'd2;

  localparam logic [PREFIX_W-1:0] PREFIX_BYTES_RST   = 64'd8995;
  localparam logic [PLEN_W-1:0]   PREFIX_LEN_RST     = 4'd2;
  localparam logic                CLEANUP_ENABLE_RST = 1'b1;

  // Cleanup rules in priority order, then one extra entry for a plain space.
  localparam int RULE_COUNT = 11;
  localparam int RULE_W     = 4;
  localparam int TEXT_MAX   = 6;
  localparam int TEXT_W     = 8 * TEXT_MAX;
  localparam int LEN_W      = 3;
  localparam logic [RULE_W-1:0] RULE_SPACE = 4'd11;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       token_begin;
    logic       token_end;
    logic       token_empty;
    logic       stream_begin;
  } wtj_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       token_done;
  } wtj_out_t;

  // The tail is the matched text after the leading space. Strings are
  // right-aligned, so the first character sits in the highest used byte.
  typedef struct packed {
    logic [TEXT_W-1:0] tail;
    logic [LEN_W-1:0]  tail_len;
    logic [TEXT_W-1:0] sub;
    logic [LEN_W-1:0]  sub_len;
  } rule_t;

  typedef struct packed {
    logic accept;
    logic pass_load;
    logic decide;
    logic sub_load;
    logic hold_load;
  } wtj_cmd_t;

  typedef struct packed {
    logic job_pass;
    logic job_resolve;
    logic dec_sub;
    logic dec_hold;
    logic have_hold;
    logic sub_last;
    logic hold_last;
    logic can_load;
  } wtj_status_t;

  function automatic rule_t rule_info(input logic [RULE_W-1:0] r);
    rule_t ri;
    ri = '0;
    case (r)
      4'd0: begin
        ri.tail = "do not"; ri.tail_len = 3'd6; ri.sub = " don't"; ri.sub_len = 3'd6;
      end
      4'd1: begin
        ri.tail = "n't"; ri.tail_len = 3'd3; ri.sub = "n't"; ri.sub_len = 3'd3;
      end
      4'd2: begin
        ri.tail = "'ve"; ri.tail_len = 3'd3; ri.sub = "'ve"; ri.sub_len = 3'd3;
      end
      4'd3: begin
        ri.tail = "'re"; ri.tail_len = 3'd3; ri.sub = "'re"; ri.sub_len = 3'd3;
      end
      4'd4: begin
        ri.tail = "' "; ri.tail_len = 3'd2; ri.sub = "'"; ri.sub_len = 3'd1;
      end
      4'd5: begin
        ri.tail = "'m"; ri.tail_len = 3'd2; ri.sub = "'m"; ri.sub_len = 3'd2;
      end
      4'd6: begin
        ri.tail = "'s"; ri.tail_len = 3'd2; ri.sub = "'s"; ri.sub_len = 3'd2;
      end
      4'd7: begin
        ri.tail = "."; ri.tail_len = 3'd1; ri.sub = "."; ri.sub_len = 3'd1;
      end
      4'd8: begin
        ri.tail = "?"; ri.tail_len = 3'd1; ri.sub = "?"; ri.sub_len = 3'd1;
      end
      4'd9: begin
        ri.tail = "!"; ri.tail_len = 3'd1; ri.sub = "!"; ri.sub_len = 3'd1;
      end
      4'd10: begin
        ri.tail = ","; ri.tail_len = 3'd1; ri.sub = ","; ri.sub_len = 3'd1;
      end
      default: begin
        ri.tail = '0; ri.tail_len = 3'd0; ri.sub = " "; ri.sub_len = 3'd1;
      end
    endcase
    return ri;
  endfunction

endpackage

@@ sv/wordpiece_token_joiner_top.sv @@
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   in_data_i   (wtj_in_t, one token byte)
// output    out_valid_o / out_ready_i out_data_o  (wtj_out_t, one text byte)
// config    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A pass-through byte is transferred, then loaded into the output register.
// A byte that closes the hold is transferred, then decided on in the decision state,
// then its output bytes leave through the output register one byte per cycle
// while it is not stalled.
// Reset is asynchronous and active low; there is no clearing pass.
// The output register stalls the emitter while it holds a byte and out_ready_i is low.
module wordpiece_token_joiner_top
  import wtj_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wtj_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wtj_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  wtj_cmd_t    cmd;
  wtj_status_t status;

  wtj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wtj_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ sv/wtj_ctrl.sv @@
module wtj_ctrl
  import wtj_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  wtj_status_t status_i,
  output wtj_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PASS   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SUBST  = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.job_pass) begin
            state_d = ST_PASS;
          end else if (status_i.job_resolve) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_PASS: begin
        if (status_i.can_load) begin
          cmd_o.pass_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (status_i.dec_sub) begin
          state_d = ST_SUBST;
        end else if (status_i.dec_hold) begin
          state_d = ST_HOLD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUBST: begin
        if (status_i.can_load) begin
          cmd_o.sub_load = 1'b1;
          if (status_i.sub_last) begin
            state_d = status_i.have_hold ? ST_HOLD : ST_IDLE;
          end
        end
      end
      ST_HOLD: begin
        if (status_i.can_load) begin
          cmd_o.hold_load = 1'b1;
          if (status_i.hold_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/wtj_datapath.sv @@
module wtj_datapath
  import wtj_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wtj_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wtj_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  wtj_cmd_t             cmd_i,
  output wtj_status_t          status_o
);

  logic [PREFIX_W-1:0] prefix_q;
  logic [PLEN_W-1:0]   plen_cfg_q;
  logic                cleanup_q;

  logic             fpt_q, fpt_d;
  logic             mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       hold_q [HOLD_DEPTH];

  logic             job_fpt_q, job_fpt_d;
  logic [CNT_W-1:0] job_n_q, job_n_d;
  logic             job_done_q, job_done_d;
  logic [7:0]       job_byte_q;
  logic             job_pass, job_resolve, hold_we;
  logic [CNT_W-1:0] wr_cnt;

  logic             eff_mode, fpt_eff;
  logic [CNT_W-1:0] eff_cnt, new_cnt;

  logic [RULE_W-1:0] rule_q, dec_rule;
  logic [LEN_W-1:0]  slen_q, dec_slen, j_q;
  logic [CNT_W-1:0]  ptr_q, dec_start;
  logic              have_hold_q;

  logic [PLEN_W-1:0] plen;
  logic              pre_ok, hit, found, ok;
  logic [RULE_W-1:0] found_rule;
  logic [LEN_W-1:0]  found_tlen, found_slen;
  rule_t             ri, rs;
  logic [LEN_W-1:0]  sub_pos;
  logic [7:0]        sub_byte;
  logic              sub_last, hold_last, can_load;

  logic     out_valid_q, out_valid_d;
  wtj_out_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   <= PREFIX_BYTES_RST;
      plen_cfg_q <= PREFIX_LEN_RST;
      cleanup_q  <= CLEANUP_ENABLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREFIX_BYTES:   prefix_q   <= cfg_data_i[PREFIX_W-1:0];
        CFG_PREFIX_LEN:     plen_cfg_q <= cfg_data_i[PLEN_W-1:0];
        CFG_CLEANUP_ENABLE: cleanup_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Token bookkeeping for the item on the input port.
  always_comb begin
    eff_mode    = in_data_i.token_begin ? 1'b0 : mode_q;
    eff_cnt     = in_data_i.token_begin ? '0 : cnt_q;
    new_cnt     = eff_cnt + 1'b1;
    fpt_eff     = fpt_q | (in_data_i.stream_begin && !eff_mode && (eff_cnt == '0));
    fpt_d       = fpt_q;
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    job_pass    = 1'b0;
    job_resolve = 1'b0;
    job_fpt_d   = fpt_q;
    job_n_d     = '0;
    job_done_d  = 1'b0;
    hold_we     = 1'b0;
    wr_cnt      = eff_cnt;
    if (in_data_i.token_empty) begin
      job_fpt_d   = fpt_q | in_data_i.stream_begin;
      job_resolve = 1'b1;
      job_done_d  = 1'b1;
      mode_d      = 1'b0;
      cnt_d       = '0;
      fpt_d       = 1'b0;
    end else if (eff_mode) begin
      job_pass = 1'b1;
      if (in_data_i.token_end) begin
        mode_d     = 1'b0;
        fpt_d      = 1'b0;
        job_done_d = 1'b1;
      end
    end else begin
      hold_we   = 1'b1;
      job_fpt_d = fpt_eff;
      if (in_data_i.token_end || (new_cnt == CNT_W'(HOLD_DEPTH))) begin
        job_resolve = 1'b1;
        job_n_d     = new_cnt;
        cnt_d       = '0;
        if (in_data_i.token_end) begin
          mode_d     = 1'b0;
          fpt_d      = 1'b0;
          job_done_d = 1'b1;
        end else begin
          mode_d = 1'b1;
          fpt_d  = fpt_eff;
        end
      end else begin
        cnt_d  = new_cnt;
        mode_d = 1'b0;
        fpt_d  = fpt_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpt_q  <= 1'b1;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.accept) begin
      fpt_q  <= fpt_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      job_fpt_q  <= job_fpt_d;
      job_n_q    <= job_n_d;
      job_done_q <= job_done_d;
      job_byte_q <= in_data_i.byte_value;
      if (hold_we) begin
        hold_q[wr_cnt[HOLD_AW-1:0]] <= in_data_i.byte_value;
      end
    end
  end

  // Held bytes: first token kept, or prefix strip, cleanup rule or space.
  always_comb begin
    plen = (plen_cfg_q > PLEN_W'(MAX_PREFIX)) ? PLEN_W'(MAX_PREFIX) : plen_cfg_q;
    pre_ok = 1'b1;
    for (int i = 0; i < MAX_PREFIX; i++) begin
      if ((PLEN_W'(i) < plen) && (hold_q[HOLD_AW'(i)] != prefix_q[8*i +: 8])) begin
        pre_ok = 1'b0;
      end
    end
    hit = !job_fpt_q && (plen != '0) && (PLEN_W'(job_n_q) >= plen) && pre_ok;

    found      = 1'b0;
    found_rule = RULE_SPACE;
    found_tlen = '0;
    found_slen = '0;
    for (int r = 0; r < RULE_COUNT; r++) begin
      ri = rule_info(RULE_W'(r));
      ok = (job_n_q >= CNT_W'(ri.tail_len));
      for (int i = 0; i < TEXT_MAX; i++) begin
        if ((LEN_W'(i) < ri.tail_len) &&
            (hold_q[HOLD_AW'(i)] != ri.tail[8*(32'(ri.tail_len) - 1 - i) +: 8])) begin
          ok = 1'b0;
        end
      end
      if (ok && !found) begin
        found      = 1'b1;
        found_rule = RULE_W'(r);
        found_tlen = ri.tail_len;
        found_slen = ri.sub_len;
      end
    end

    if (job_fpt_q) begin
      dec_rule  = RULE_SPACE;
      dec_slen  = '0;
      dec_start = '0;
    end else if (hit) begin
      dec_rule  = RULE_SPACE;
      dec_slen  = '0;
      dec_start = CNT_W'(plen);
    end else if (cleanup_q && found) begin
      dec_rule  = found_rule;
      dec_slen  = found_slen;
      dec_start = CNT_W'(found_tlen);
    end else begin
      dec_rule  = RULE_SPACE;
      dec_slen  = LEN_W'(1);
      dec_start = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      rule_q      <= dec_rule;
      slen_q      <= dec_slen;
      ptr_q       <= dec_start;
      have_hold_q <= (dec_start < job_n_q);
      j_q         <= '0;
    end else begin
      if (cmd_i.sub_load) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.hold_load) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_comb begin
    rs        = rule_info(rule_q);
    sub_pos   = slen_q - 1'b1 - j_q;
    sub_byte  = rs.sub[{sub_pos, 3'b000} +: 8];
    sub_last  = (j_q + 1'b1) == slen_q;
    hold_last = (ptr_q + 1'b1) == job_n_q;
    can_load  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.pass_load) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = job_byte_q;
      out_d.last_of_run = 1'b1;
      out_d.token_done  = job_done_q;
    end else if (cmd_i.sub_load) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = sub_byte;
      out_d.last_of_run = sub_last && !have_hold_q;
      out_d.token_done  = sub_last && !have_hold_q && job_done_q;
    end else if (cmd_i.hold_load) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = hold_q[ptr_q[HOLD_AW-1:0]];
      out_d.last_of_run = hold_last;
      out_d.token_done  = hold_last && job_done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.job_pass    = job_pass;
  assign status_o.job_resolve = job_resolve;
  assign status_o.dec_sub     = (dec_slen != '0);
  assign status_o.dec_hold    = (dec_start < job_n_q);
  assign status_o.have_hold   = have_hold_q;
  assign status_o.sub_last    = sub_last;
  assign status_o.hold_last   = hold_last;
  assign status_o.can_load    = can_load;

endmodule

@@ verif/wordpiece_token_joiner_checker.sv @@
`timescale 1ns / 100ps

module wordpiece_token_joiner_checker
  import wtj_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  wtj_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  wtj_out_t             out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef enum logic [1:0] {
    MODE_DECIDE = 2'd0,
    MODE_COPY   = 2'd1
  } token_mode_e;

  logic [PREFIX_W-1:0] prefix_q;
  logic [PLEN_W-1:0]   prefix_len_q;
  logic                cleanup_q;

  logic                first_pending;
  token_mode_e         mode;
  logic [7:0]          hold [HOLD_DEPTH];
  int                  hold_cnt;

  wtj_out_t            expected_text[$];
  wtj_out_t            item_text[$];
  int                  fails;

  function automatic string rule_match(input int r);
    case (r)
      0: return " do not";
      1: return " n't";
      2: return " 've";
      3: return " 're";
      4: return " ' ";
      5: return " 'm";
      6: return " 's";
      7: return " .";
      8: return " ?";
      9: return " !";
      10: return " ,";
      default: return "";
    endcase
  endfunction

  function automatic string rule_subst(input int r);
    case (r)
      0: return " don't";
      1: return "n't";
      2: return "'ve";
      3: return "'re";
      4: return "'";
      5: return "'m";
      6: return "'s";
      7: return ".";
      8: return "?";
      9: return "!";
      10: return ",";
      default: return "";
    endcase
  endfunction

  function automatic void put_text(input logic [7:0] b);
    wtj_out_t r;
    r.out_byte    = b;
    r.last_of_run = 1'b0;
    r.token_done  = 1'b0;
    item_text.push_back(r);
  endfunction

  // Emits any space or substitution, then held bytes from start to n.
  function automatic void decide_token(input int n);
    int    start;
    int    plen;
    int    mlen;
    logic  space;
    logic  hit;
    logic  ok;
    logic  matched;
    string m;
    string s;
    start = 0;
    space = 1'b0;
    plen  = (prefix_len_q > MAX_PREFIX) ? MAX_PREFIX : int'(prefix_len_q);
    if (!first_pending) begin
      hit = (plen > 0) && (n >= plen);
      for (int i = 0; hit && i < plen; i++) begin
        if (hold[i] != prefix_q[8*i +: 8]) hit = 1'b0;
      end
      if (hit) start = plen;
      else space = 1'b1;
    end
    if (space) begin
      matched = 1'b0;
      if (cleanup_q) begin
        for (int r = 0; r < RULE_COUNT && !matched; r++) begin
          m    = rule_match(r);
          mlen = m.len();
          ok   = (n + 1 >= mlen);
          for (int i = 1; ok && i < mlen; i++) begin
            if (hold[i-1] != m[i]) ok = 1'b0;
          end
          if (ok) begin
            s = rule_subst(r);
            for (int i = 0; i < s.len(); i++) put_text(s[i]);
            start   = mlen - 1;
            matched = 1'b1;
          end
        end
      end
      if (!matched) put_text(" ");
    end
    for (int i = start; i < n && i < HOLD_DEPTH; i++) put_text(hold[i]);
  endfunction

  function automatic void predict_text(input wtj_in_t it);
    logic     done;
    wtj_out_t tail;
    done = 1'b0;
    item_text.delete();
    if (it.token_empty) begin
      if (it.stream_begin) first_pending = 1'b1;
      mode     = MODE_DECIDE;
      hold_cnt = 0;
      decide_token(0);
      first_pending = 1'b0;
      done = 1'b1;
    end else begin
      if (it.token_begin) begin
        mode     = MODE_DECIDE;
        hold_cnt = 0;
      end
      if (it.stream_begin && mode == MODE_DECIDE && hold_cnt == 0) first_pending = 1'b1;
      if (mode == MODE_COPY) begin
        put_text(it.byte_value);
        if (it.token_end) begin
          mode = MODE_DECIDE;
          first_pending = 1'b0;
          done = 1'b1;
        end
      end else begin
        if (hold_cnt < HOLD_DEPTH) begin
          hold[hold_cnt] = it.byte_value;
          hold_cnt++;
        end
        if (it.token_end || hold_cnt >= HOLD_DEPTH) begin
          decide_token(hold_cnt);
          hold_cnt = 0;
          if (it.token_end) begin
            mode = MODE_DECIDE;
            first_pending = 1'b0;
            done = 1'b1;
          end else begin
            mode = MODE_COPY;
          end
        end
      end
    end
    if (item_text.size() > 0) begin
      tail = item_text.pop_back();
      tail.last_of_run = 1'b1;
      tail.token_done  = done;
      item_text.push_back(tail);
    end
    foreach (item_text[i]) expected_text.push_back(item_text[i]);
  endfunction

  function automatic void check_text(input wtj_out_t got);
    wtj_out_t want;
    if (expected_text.size() == 0) begin
      $error("out_byte: expected no transfer, got %0h", got.out_byte);
      fails++;
    end else begin
      want = expected_text.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        fails++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        fails++;
      end
      if (got.token_done !== want.token_done) begin
        $error("token_done: expected %0b, got %0b", want.token_done, got.token_done);
        fails++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q      = PREFIX_BYTES_RST;
      prefix_len_q  = PREFIX_LEN_RST;
      cleanup_q     = CLEANUP_ENABLE_RST;
      first_pending = 1'b1;
      mode          = MODE_DECIDE;
      hold_cnt      = 0;
      fails         = 0;
      expected_text.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PREFIX_BYTES: prefix_q = cfg_data_i[PREFIX_W-1:0];
          CFG_PREFIX_LEN: prefix_len_q = cfg_data_i[PLEN_W-1:0];
          CFG_CLEANUP_ENABLE: cleanup_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_text(in_data_i);
      if (out_valid_i && out_ready_i) check_text(out_data_i);
      fail_count_o <= fails;
      pending_o    <= expected_text.size();
    end
  end

endmodule

@@ verif/wordpiece_token_joiner_top_test.sv @@
`timescale 1ns / 100ps

module wordpiece_token_joiner_top_test;
  import wtj_pkg::*;

  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEGMENT_ITEMS  = 62;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  wtj_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  wtj_out_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int                   check_fails;
  int                   text_pending;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   items_sent    = 0;
  int                   idle_cycles   = 0;

  logic [PREFIX_W-1:0]  cfg_prefix = PREFIX_BYTES_RST;
  logic [PLEN_W-1:0]    cfg_len    = PREFIX_LEN_RST;
  logic [7:0]           tok_buf[$];

  wordpiece_token_joiner_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  wordpiece_token_joiner_checker joiner_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (check_fails),
    .pending_o    (text_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic string cleanup_word(input int r);
    case (r)
      0: return "do not";
      1: return "n't";
      2: return "'ve";
      3: return "'re";
      4: return "' ";
      5: return "'m";
      6: return "'s";
      7: return ".";
      8: return "?";
      9: return "!";
      default: return ",";
    endcase
  endfunction

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    logic [7:0] b;
    b = 8'($urandom_range(lo, hi));
    return b;
  endfunction

  function automatic void load_word(input string w);
    tok_buf.delete();
    for (int i = 0; i < w.len(); i++) tok_buf.push_back(w[i]);
  endfunction

  // Mostly well-formed tokens: continuations, cleanup words (some cut short),
  // plain words, and raw bytes, some of them enough to overflow the hold buffer.
  function automatic void build_token();
    int    kind;
    int    plen;
    int    count;
    string w;
    tok_buf.delete();
    kind = $urandom_range(0, 9);
    plen = (cfg_len > MAX_PREFIX) ? MAX_PREFIX : int'(cfg_len);
    case (kind)
      0, 1: begin
        for (int i = 0; i < plen; i++) tok_buf.push_back(cfg_prefix[8*i +: 8]);
        repeat ($urandom_range(0, 4)) tok_buf.push_back(rand_byte(97, 122));
      end
      2, 3: begin
        w = cleanup_word($urandom_range(0, RULE_COUNT - 1));
        count = w.len();
        if (count > 1 && $urandom_range(0, 3) == 0) count--;
        for (int i = 0; i < count; i++) tok_buf.push_back(w[i]);
        if ($urandom_range(0, 2) == 0) tok_buf.push_back(rand_byte(97, 122));
      end
      4, 5, 6: begin
        repeat ($urandom_range(1, 6)) tok_buf.push_back(rand_byte(97, 122));
      end
      7, 8: begin
        repeat ($urandom_range(1, 8)) tok_buf.push_back(rand_byte(0, 255));
      end
      default: begin
        repeat ($urandom_range(9, 16)) tok_buf.push_back(rand_byte(0, 255));
      end
    endcase
    if (tok_buf.size() == 0) tok_buf.push_back(rand_byte(0, 255));
  endfunction

  task automatic send_item(input wtj_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_token(input logic sbeg, input logic explicit_begin, input logic finish);
    wtj_in_t it;
    for (int i = 0; i < tok_buf.size(); i++) begin
      it.byte_value   = tok_buf[i];
      it.token_begin  = (i == 0) && explicit_begin;
      it.token_end    = finish && (i == tok_buf.size() - 1);
      it.token_empty  = 1'b0;
      it.stream_begin = ((i == 0) && sbeg) || ($urandom_range(0, 24) == 0);
      send_item(it);
    end
  endtask

  task automatic send_empty(input logic sbeg);
    wtj_in_t it;
    logic [31:0] rnd;
    rnd = $urandom;
    it = rnd[$bits(wtj_in_t)-1:0];
    it.token_empty  = 1'b1;
    it.stream_begin = sbeg;
    send_item(it);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (text_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [PREFIX_W-1:0] prefix, input logic [PLEN_W-1:0] plen,
                            input logic clean);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PREFIX_BYTES;
    cfg_data <= prefix;
    @(posedge clk);
    cfg_idx  <= CFG_PREFIX_LEN;
    cfg_data <= {{(CFG_W - PLEN_W){1'b0}}, plen};
    @(posedge clk);
    cfg_idx  <= CFG_CLEANUP_ENABLE;
    cfg_data <= {{(CFG_W - 1){1'b0}}, clean};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_prefix  = prefix;
    cfg_len     = plen;
  endtask

  task automatic random_step();
    int pick;
    logic [$bits(wtj_in_t)-1:0] raw;
    logic [31:0] rnd;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      send_empty($urandom_range(0, 3) == 0);
    end else if (pick < 12) begin
      rnd = $urandom;
      raw = rnd[$bits(wtj_in_t)-1:0];
      send_item(raw);
    end else begin
      build_token();
      send_token($urandom_range(0, 9) == 0, $urandom_range(0, 99) < 85,
                 $urandom_range(0, 99) >= 6);
    end
  endtask

  initial begin
    logic [PLEN_W-1:0] plen;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 16;
    recv_idle_pct = 73;
    @(posedge clk);
    set_config(64'h2323, 4'd2, 1'b1);

    send_empty(1'b1);
    load_word("##");
    send_token(1'b0, 1'b1, 1'b1);
    load_word("do not");
    send_token(1'b0, 1'b1, 1'b1);
    load_word("' ");
    send_token(1'b0, 1'b1, 1'b1);
    load_word("!");
    send_token(1'b0, 1'b0, 1'b1);
    send_empty(1'b0);
    tok_buf.delete();
    for (int i = 0; i < 9; i++) tok_buf.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
    send_token(1'b0, 1'b1, 1'b1);
    load_word("ab");
    send_token(1'b0, 1'b1, 1'b0);
    load_word("c");
    send_token(1'b0, 1'b1, 1'b1);

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 73;
        recv_idle_pct = 16;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_for_drain();
      case (seg)
        0: set_config({$urandom, $urandom}, 4'd8, 1'b1);
        1: set_config('1, 4'd15, 1'b0);
        2: set_config('0, 4'd0, 1'b1);
        3: begin
          plen = PLEN_W'($urandom_range(1, 7));
          set_config({$urandom, $urandom}, plen, 1'($urandom_range(0, 1)));
        end
        4: set_config(64'h2323, 4'd9, 1'b1);
        default: set_config(64'h2323, 4'd2, 1'b1);
      endcase
      for (int goal = items_sent + SEGMENT_ITEMS; items_sent < goal; ) random_step();
    end

    wait_for_drain();
    if (check_fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/wtj_pkg.sv
sv/wtj_ctrl.sv
sv/wtj_datapath.sv
sv/wordpiece_token_joiner_top.sv
verif/wordpiece_token_joiner_checker.sv
verif/wordpiece_token_joiner_top_test.sv
